// ===== rtl/fingerprint_linear_probe_hash_table_unit_defines.svh =====
// assertion macros for the fingerprint hash table unit
`ifndef FINGERPRINT_LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`define FINGERPRINT_LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define FLP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same, with no reset gate
`define FLP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/flph_pkg.sv =====
// package with types, constants and a sign extension helper for the hash table unit
`default_nettype none
package flph_pkg;
    localparam int DEPTH_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int SIZE_BITS      = 11;
    localparam int FP_BITS        = 31;
    localparam logic [31:0] DJB_SEED = 32'd5381;
    localparam logic [31:0] FP_MASK  = 32'h7FFF_FFFF;

    localparam logic [1:0] ST_ADDED     = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;
    localparam logic       MODE_ADD     = 1'b0;
    localparam logic       MODE_FIND    = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  key_byte;
        logic        key_end;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot_index;
        logic [31:0] found_value;
    } out_item_t;

    typedef enum logic [2:0] {
        S_HASH, S_MOD, S_CLEAR, S_PROBE_RD, S_PROBE_CHK, S_OUT
    } state_t;

    // hash state handed from hasher to controller
    typedef struct packed {
        logic [31:0] bkdr;
        logic [31:0] ap;
        logic [31:0] djb;
    } hash_t;

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction
endpackage
`default_nettype wire

// ===== rtl/flph_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module flph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/flph_hasher.sv =====
// running bkdr, ap and djb hashes over key bytes
`default_nettype none
module flph_hasher import flph_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] key_byte,
    input  wire logic       key_end,
    output hash_t           hash_next
);
    hash_t       hash_reg;
    logic        parity_reg;
    logic [31:0] c;
    logic [31:0] ap;

    always_comb
    begin
        c  = sext8(key_byte);
        ap = hash_reg.ap;
        hash_next.bkdr = hash_reg.bkdr * 32'd131 + c;
        if (!parity_reg)
            hash_next.ap = ap ^ ((ap << 7) ^ c ^ (ap >> 3));
        else
            hash_next.ap = ap ^ ~((ap << 11) ^ c ^ (ap >> 5));
        hash_next.djb = hash_reg.djb + (hash_reg.djb << 5) + c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg   <= '{bkdr: '0, ap: '0, djb: DJB_SEED};
            parity_reg <= 1'b0;
        end
        else if (step)
        begin
            if (key_end)
            begin
                hash_reg   <= '{bkdr: '0, ap: '0, djb: DJB_SEED};
                parity_reg <= 1'b0;
            end
            else
            begin
                hash_reg   <= hash_next;
                parity_reg <= ~parity_reg;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/flph_modulo.sv =====
// iterative restoring remainder, one bit a cycle
`default_nettype none
module flph_modulo import flph_pkg::*; #(
    parameter int SBITS = SIZE_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [30:0]      dividend,
    input  wire logic [SBITS-1:0] divisor,
    output logic                  done,
    output logic      [SBITS-1:0] rem
);
    localparam int CBITS = $clog2(FP_BITS + 1);
    logic [30:0]      q_reg;
    logic [SBITS:0]   r_reg;
    logic [SBITS-1:0] d_reg;
    logic [CBITS-1:0] cnt_reg;
    logic             busy_reg;
    logic [SBITS:0]   shifted;

    assign shifted = {r_reg[SBITS-1:0], q_reg[30]};
    assign done    = busy_reg && (cnt_reg == '0);
    assign rem     = r_reg[SBITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CBITS'(FP_BITS);
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            q_reg <= {q_reg[29:0], 1'b0};
            if (shifted >= {1'b0, d_reg})
                r_reg <= shifted - {1'b0, d_reg};
            else
                r_reg <= shifted;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/fingerprint_linear_probe_hash_table_unit.sv =====
// top level: byte hashing, home slot modulo and probe walk over the slot memory
// non-last bytes are taken one per cycle while no result item is pending; after a last byte the
//   result item follows the modulo, a read and a check state per probed slot, and the S_OUT state
// throughput: one key operation at a time, bounded by the divider and the probe walk
// reset: clears hashes and control, then sweeps the valid memory one slot a cycle while in_stall
//   stays high; table_size resets to 1024
`default_nettype none
module fingerprint_linear_probe_hash_table_unit import flph_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_item_t             in_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_item_t                 out_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [SIZE_BITS-1:0] cfg_data
);
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int SB  = $clog2(TABLE_DEPTH + 1);
    localparam int EW  = 1 + 2 * FP_BITS + VALUE_BITS;
    localparam logic [SB-1:0] DEPTH_N = SB'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [SIZE_BITS-1:0] size_reg;
    logic [SB-1:0]        n_slots;     // clamped active slot count
    logic [AW-1:0]        pos_reg;
    logic [SB-1:0]        left_reg;    // slots still to probe
    logic [FP_BITS-1:0]   fa_reg, fb_reg;
    logic [VALUE_BITS-1:0] pay_reg;
    logic                 mode_reg;
    out_item_t            res_reg;
    logic                 out_valid_reg;

    logic                 accept;
    hash_t                hash_next;
    logic                 mod_start, mod_done;
    logic [SB-1:0]        mod_rem;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [EW-1:0]        ram_wdata, ram_rdata;
    logic                 e_valid;
    logic [FP_BITS-1:0]   e_fa, e_fb;
    logic [VALUE_BITS-1:0] e_pay;
    logic                 hit, last_probe;
    logic [AW-1:0]        pos_inc;

    // config is taken at any time; the user must write it only while idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_BITS'(1024);
        else if (cfg_valid)
            size_reg <= cfg_data;
    end

    // clamp the size into 1 .. TABLE_DEPTH
    always_comb
    begin
        if (size_reg == '0)
            n_slots = SB'(1);
        else if ({{(32-SIZE_BITS){1'b0}}, size_reg} > 32'(TABLE_DEPTH))
            n_slots = DEPTH_N;
        else
            n_slots = SB'(size_reg);
    end

    assign in_stall = (state_reg != S_HASH) || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    flph_hasher u_hasher (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .key_byte  (in_item.key_byte),
        .key_end   (in_item.key_end),
        .hash_next (hash_next)
    );

    assign mod_start = accept && in_item.key_end;

    flph_modulo #(.SBITS(SB)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (hash_next.bkdr[30:0]),
        .divisor  (n_slots),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // slot entry: valid, fingerprint a, fingerprint b, payload
    flph_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign {e_valid, e_fa, e_fb, e_pay} = ram_rdata;
    assign hit = (mode_reg == MODE_ADD) ? !e_valid
               : (e_valid && e_fa == fa_reg && e_fb == fb_reg);
    assign last_probe = (left_reg == SB'(1));
    assign pos_inc = (SB'(pos_reg) + SB'(1) >= n_slots) ? '0 : pos_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:     if (pos_reg == AW'(TABLE_DEPTH - 1)) state_next = S_HASH;
            S_HASH:      if (mod_start) state_next = S_MOD;
            S_MOD:       if (mod_done) state_next = S_PROBE_RD;
            S_PROBE_RD:  state_next = S_PROBE_CHK;
            S_PROBE_CHK: if (hit || last_probe) state_next = S_OUT;
                         else state_next = S_PROBE_RD;
            S_OUT:       state_next = S_HASH;
            default:     state_next = S_HASH;
        endcase
    end

    // memory port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = pos_reg;
        ram_wdata = {1'b1, fa_reg, fb_reg, pay_reg};
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            S_PROBE_CHK: ram_we = hit && (mode_reg == MODE_ADD);
            default:     ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:     pos_reg <= pos_reg + 1'b1;
                S_MOD:       if (mod_done) pos_reg <= mod_rem[AW-1:0];
                S_PROBE_CHK: if (!(hit || last_probe)) pos_reg <= pos_inc;
                S_OUT:       out_valid_reg <= 1'b1;
                default:     pos_reg <= pos_reg;
            endcase
        end
    end

    // payload, probe count and result registers
    always_ff @(posedge clk)
    begin
        if (mod_start)
        begin
            mode_reg <= in_item.mode;
            fa_reg   <= hash_next.ap[30:0];
            fb_reg   <= hash_next.djb[30:0];
            pay_reg  <= in_item.value[VALUE_BITS-1:0];
        end
        if (state_reg == S_MOD)
            left_reg <= n_slots;
        else if (state_reg == S_PROBE_CHK)
            left_reg <= left_reg - 1'b1;
        if (state_reg == S_PROBE_CHK && (hit || last_probe))
        begin
            res_reg.status      <= (mode_reg == MODE_ADD) ? (hit ? ST_ADDED : ST_FULL)
                                                          : (hit ? ST_FOUND : ST_NOT_FOUND);
            res_reg.slot_index  <= hit ? 10'(pos_reg) : '0;
            res_reg.found_value <= (hit && mode_reg == MODE_FIND) ? 32'(e_pay) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = res_reg;
endmodule
`default_nettype wire

// ===== rtl/flph_checker.sv =====
// port level checker for the hash table unit, bound to the top level
`default_nettype none
`include "fingerprint_linear_probe_hash_table_unit_defines.svh"
module flph_checker import flph_pkg::*; (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_item_t  in_item,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_item
);
    `FLP_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_item), "result item changed while stalled")
    `FLP_ASSERT(a_no_take_while_out, clk, rst_n, out_valid |-> in_stall, "item taken while result pending")
    `FLP_ASSERT(a_nonlast_no_result, clk, rst_n, in_valid && !in_stall && !in_item.key_end |=> !out_valid, "result after non-last byte")
    `FLP_ASSERT(a_add_zero_val, clk, rst_n, out_valid && (out_item.status == ST_ADDED || out_item.status == ST_FULL) |-> out_item.found_value == '0, "found_value on add")
    `FLP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result during reset")
endmodule

bind fingerprint_linear_probe_hash_table_unit flph_checker u_flph_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
`default_nettype wire
